[hdl/rpn_pkg.sv]
// shared types and constants for the rpn stack expression unit
`timescale 1ns / 1ps

package rpn_pkg;

    localparam int MEM_WORDS = 1024;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int WORD_W    = 16;
    localparam int CFG_W     = 10;
    localparam int SP_W      = 10;
    localparam logic [CFG_W-1:0] STACK_START_RESET = CFG_W'(768);

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [4:0] {
        FN_END      = 5'd0,
        FN_PUSH_IMM = 5'd1,
        FN_PUSH_REF = 5'd2,
        FN_PUSH_IND = 5'd3,
        FN_POP_ST   = 5'd4,
        FN_ADD      = 5'd5,
        FN_SUB      = 5'd6,
        FN_MUL      = 5'd7,
        FN_DIV      = 5'd8,
        FN_MOD      = 5'd9,
        FN_EQ       = 5'd10,
        FN_LT       = 5'd11,
        FN_LE       = 5'd12,
        FN_GT       = 5'd13,
        FN_GE       = 5'd14,
        FN_NE       = 5'd15,
        FN_LAND     = 5'd16,
        FN_LOR      = 5'd17,
        FN_LNOT     = 5'd18,
        FN_BAND     = 5'd19,
        FN_BOR      = 5'd20,
        FN_BXOR     = 5'd21,
        FN_MIN      = 5'd22,
        FN_MAX      = 5'd23,
        FN_ABS      = 5'd24,
        FN_BNOT     = 5'd25,
        FN_ISQRT    = 5'd26
    } t_func;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD2,
        ST_EXEC,
        ST_DIV,
        ST_SQRT,
        ST_WR,
        ST_TOPRD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [4:0]         func;
        logic signed [15:0] operand;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] top_value;
        logic [SP_W-1:0]    stack_pointer;
        logic               expression_done;
        logic               divide_by_zero;
    } t_out_word;

endpackage

[hdl/rpn_stack_expression_unit.sv]
// rpn stack expression unit: memory-based stack machine with serial divide and square root
//
// One decoded instruction is taken per word on the input channel and one result word
// follows on the output channel. All operands, variables and the evaluation stack live in
// a single 1024 x 16 synchronous word memory with one read and one write port; most
// instructions read, modify and write it back, and every instruction then reads the new top
// of stack. After reset the memory is cleared one word per cycle, and no input word is
// accepted until the clearing pass is complete. Each instruction goes through the memory
// reads, operation, write and top-of-stack read that it needs, in that order; divide and
// modulo add the one-bit-per-cycle divider, integer square root a serial root loop, and
// a zero divisor skips the divider. The next word can be accepted in the same cycle as the
// result appears. A finished result waits in an output register while the next word is
// accepted. A stack_start write loads the stack pointer and closes any open expression.
`timescale 1ns / 1ps

module rpn_stack_expression_unit
    import rpn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_word     r_mem [MEM_WORDS];
    t_word     r_rdata;

    t_state    r_state, n_state;
    t_func     r_func, n_func;
    t_word     r_opnd, n_opnd;
    t_addr     r_sp, n_sp;
    t_addr     r_base, n_base;
    logic      r_open, n_open;
    t_word     r_b, n_b;
    logic      r_aneg, n_aneg;
    logic      r_qneg, n_qneg;
    logic      r_dz, n_dz;
    logic      r_done, n_done;
    t_word     r_res, n_res;
    t_addr     r_waddr, n_waddr;
    t_word     r_rem, n_rem;
    t_word     r_quo, n_quo;
    t_word     r_dvs, n_dvs;
    t_word     r_sx, n_sx;
    t_word     r_bit, n_bit;
    logic [4:0] r_cnt, n_cnt;
    t_addr     r_clr, n_clr;
    logic      r_ovalid, n_ovalid;
    t_out_word r_out, n_out;

    logic      w_we, w_re;
    t_addr     w_waddr, w_raddr;
    t_word     w_wdata;

    function automatic t_addr idx_addr(input t_word idx, input t_addr base);
        if (idx[WORD_W-1]) begin
            return t_addr'(base + t_addr'(idx));
        end
        return t_addr'(idx);
    endfunction

    function automatic logic is_binary(input t_func f);
        return (f >= FN_ADD) && (f <= FN_MAX) && (f != FN_LNOT);
    endfunction

    function automatic t_word abs_w(input t_word v);
        return v[WORD_W-1] ? t_word'(-v) : v;
    endfunction

    logic signed [15:0] w_a, w_bs;
    t_word              w_alu;
    logic [16:0]        w_dtmp, w_stmp;
    t_word              w_dsub;

    assign w_a    = r_rdata;
    assign w_bs   = r_b;
    assign w_dtmp = {r_rem, r_quo[WORD_W-1]};
    assign w_dsub = t_word'(w_dtmp - {1'b0, r_dvs});
    assign w_stmp = {1'b0, r_quo} + {1'b0, r_bit};

    always_comb begin
        case (r_func)
            FN_ADD:  w_alu = t_word'(w_a + w_bs);
            FN_SUB:  w_alu = t_word'(w_a - w_bs);
            FN_MUL:  w_alu = t_word'(w_a * w_bs);
            FN_EQ:   w_alu = t_word'(w_a == w_bs);
            FN_LT:   w_alu = t_word'(w_a < w_bs);
            FN_LE:   w_alu = t_word'(w_a <= w_bs);
            FN_GT:   w_alu = t_word'(w_a > w_bs);
            FN_GE:   w_alu = t_word'(w_a >= w_bs);
            FN_NE:   w_alu = t_word'(w_a != w_bs);
            FN_LAND: w_alu = t_word'((w_a != 0) && (w_bs != 0));
            FN_LOR:  w_alu = t_word'((w_a != 0) || (w_bs != 0));
            FN_BAND: w_alu = w_a & w_bs;
            FN_BOR:  w_alu = w_a | w_bs;
            FN_BXOR: w_alu = w_a ^ w_bs;
            FN_MIN:  w_alu = (w_a < w_bs) ? w_a : w_bs;
            FN_MAX:  w_alu = (w_a > w_bs) ? w_a : w_bs;
            default: w_alu = '0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_opnd   = r_opnd;
        n_sp     = r_sp;
        n_base   = r_base;
        n_open   = r_open;
        n_b      = r_b;
        n_aneg   = r_aneg;
        n_qneg   = r_qneg;
        n_dz     = r_dz;
        n_done   = r_done;
        n_res    = r_res;
        n_waddr  = r_waddr;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_dvs    = r_dvs;
        n_sx     = r_sx;
        n_bit    = r_bit;
        n_cnt    = r_cnt;
        n_clr    = r_clr;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out    = r_out;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_waddr  = r_sp;
        w_raddr  = t_addr'(r_sp - 1'b1);
        w_wdata  = '0;
        o_in_ready = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                n_clr   = t_addr'(r_clr + 1'b1);
                if (r_clr == t_addr'(MEM_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_func = t_func'(i_in_word.func);
                    n_opnd = i_in_word.operand;
                    n_base = r_open ? r_base : r_sp;
                    n_open = 1'b1;
                    n_dz   = 1'b0;
                    n_done = 1'b0;
                    if (is_binary(t_func'(i_in_word.func))) begin
                        w_re    = 1'b1;
                        n_state = ST_RD2;
                    end else begin
                        case (t_func'(i_in_word.func))
                            FN_LNOT, FN_ABS, FN_BNOT, FN_ISQRT, FN_POP_ST: begin
                                w_re    = 1'b1;
                                n_state = ST_EXEC;
                            end
                            FN_PUSH_IMM: begin
                                w_we    = 1'b1;
                                w_wdata = i_in_word.operand;
                                n_sp    = t_addr'(r_sp + 1'b1);
                                n_state = ST_TOPRD;
                            end
                            FN_PUSH_REF, FN_PUSH_IND: begin
                                w_re    = 1'b1;
                                w_raddr = idx_addr(i_in_word.operand, n_base);
                                n_state = (t_func'(i_in_word.func) == FN_PUSH_REF) ?
                                          ST_EXEC : ST_RD2;
                            end
                            default: begin
                                n_done  = 1'b1;
                                n_open  = 1'b0;
                                n_state = ST_TOPRD;
                            end
                        endcase
                    end
                end
            end
            ST_RD2: begin
                w_re    = 1'b1;
                n_state = ST_EXEC;
                if (r_func == FN_PUSH_IND) begin
                    w_raddr = idx_addr(r_rdata, r_base);
                end else begin
                    n_b     = r_rdata;
                    w_raddr = t_addr'(r_sp - 2'd2);
                end
            end
            ST_EXEC: begin
                n_state = ST_TOPRD;
                if (is_binary(r_func)) begin
                    n_sp    = t_addr'(r_sp - 1'b1);
                    n_waddr = t_addr'(r_sp - 2'd2);
                    if ((r_func == FN_DIV) || (r_func == FN_MOD)) begin
                        if (r_b == '0) begin
                            n_dz    = 1'b1;
                            n_res   = '0;
                            n_state = ST_WR;
                        end else begin
                            n_aneg  = r_rdata[WORD_W-1];
                            n_qneg  = r_rdata[WORD_W-1] ^ r_b[WORD_W-1];
                            n_rem   = '0;
                            n_quo   = abs_w(r_rdata);
                            n_dvs   = abs_w(r_b);
                            n_cnt   = 5'd16;
                            n_state = ST_DIV;
                        end
                    end else begin
                        w_we    = 1'b1;
                        w_waddr = t_addr'(r_sp - 2'd2);
                        w_wdata = w_alu;
                    end
                end else begin
                    case (r_func)
                        FN_LNOT, FN_ABS, FN_BNOT: begin
                            w_we    = 1'b1;
                            w_waddr = t_addr'(r_sp - 1'b1);
                            w_wdata = (r_func == FN_LNOT) ? t_word'(r_rdata == '0) :
                                      (r_func == FN_ABS) ? abs_w(r_rdata) : ~r_rdata;
                        end
                        FN_ISQRT: begin
                            n_waddr = t_addr'(r_sp - 1'b1);
                            n_sx    = r_rdata;
                            n_quo   = '0;
                            n_bit   = t_word'(1 << 14);
                            n_cnt   = 5'd8;
                            n_state = ST_SQRT;
                        end
                        FN_POP_ST: begin
                            w_we    = 1'b1;
                            w_waddr = idx_addr(r_opnd, r_base);
                            w_wdata = r_rdata;
                            n_sp    = t_addr'(r_sp - 1'b1);
                        end
                        default: begin
                            w_we    = 1'b1;
                            w_wdata = r_rdata;
                            n_sp    = t_addr'(r_sp + 1'b1);
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (w_dtmp >= {1'b0, r_dvs}) begin
                    n_rem = w_dsub;
                    n_quo = {r_quo[WORD_W-2:0], 1'b1};
                end else begin
                    n_rem = w_dtmp[WORD_W-1:0];
                    n_quo = {r_quo[WORD_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == 5'd0) begin
                    n_rem = r_rem;
                    n_quo = r_quo;
                    if (r_func == FN_DIV) begin
                        n_res = r_qneg ? t_word'(-r_quo) : r_quo;
                    end else begin
                        n_res = r_aneg ? t_word'(-r_rem) : r_rem;
                    end
                    n_state = ST_WR;
                end
            end
            ST_SQRT: begin
                if ({1'b0, r_sx} >= w_stmp) begin
                    n_sx  = t_word'({1'b0, r_sx} - w_stmp);
                    n_quo = t_word'((r_quo >> 1) + r_bit);
                end else begin
                    n_quo = r_quo >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == 5'd1) begin
                    n_res   = (({1'b0, r_sx} >= w_stmp)) ? t_word'((r_quo >> 1) + r_bit) :
                              (r_quo >> 1);
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                w_we    = 1'b1;
                w_waddr = r_waddr;
                w_wdata = r_res;
                n_state = ST_TOPRD;
            end
            ST_TOPRD: begin
                w_re    = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid                    = 1'b1;
                    n_out.top_value             = r_rdata;
                    n_out.stack_pointer         = SP_W'(r_sp);
                    n_out.expression_done       = r_done;
                    n_out.divide_by_zero        = r_dz;
                    n_state                     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_sp   = t_addr'(i_cfg_data);
            n_base = t_addr'(i_cfg_data);
            n_open = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_sp     <= t_addr'(STACK_START_RESET);
            r_base   <= t_addr'(STACK_START_RESET);
            r_open   <= 1'b0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_sp     <= n_sp;
            r_base   <= n_base;
            r_open   <= n_open;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_opnd  <= n_opnd;
        r_b     <= n_b;
        r_aneg  <= n_aneg;
        r_qneg  <= n_qneg;
        r_dz    <= n_dz;
        r_done  <= n_done;
        r_res   <= n_res;
        r_waddr <= n_waddr;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dvs   <= n_dvs;
        r_sx    <= n_sx;
        r_bit   <= n_bit;
        r_out   <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

endmodule

[hdl/rpn_checker.sv]
// port-level checker for the rpn stack expression unit and its bind
`timescale 1ns / 1ps

module rpn_checker
    import rpn_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // one word in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while busy");

    // end never reports a zero divisor
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.expression_done && o_out_word.divide_by_zero))
        else $error("done and divide by zero both set");

    // no word taken and no result out as the clearing pass begins after reset
    a_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("ready during clearing pass");

endmodule

bind rpn_stack_expression_unit rpn_checker u_rpn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
